FILE: hw/rtl/grt_pkg.sv
package grt_pkg;

	localparam int GROUP_LOG2 = 10;
	localparam int MAX_GROUPS = 64;

	localparam int FRAME_W = 16;
	localparam int DEPTH = 1 << FRAME_W;
	localparam int COUNT_W = 11;
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;
	localparam int GCOUNT_W = 7;
	localparam int GROUP_W = 6;
	localparam int OFFSET_W = 34;
	localparam int LOG2_W = 5;
	localparam int SHIFT_W = $clog2(GROUP_LOG2 + 1);
	localparam int CMP_W = (GROUP_LOG2 + 1 > COUNT_W) ? GROUP_LOG2 + 1 : COUNT_W;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [LOG2_W-1:0] FRAME_LOG2_MIN = LOG2_W'(9);
	localparam logic [LOG2_W-1:0] FRAME_LOG2_MAX = LOG2_W'(18);
	localparam logic [LOG2_W-1:0] FRAME_LOG2_RESET = LOG2_W'(12);
	localparam logic [LOG2_W-1:0] GRANULE_LOG2_RESET = LOG2_W'(12);
	localparam logic [GCOUNT_W-1:0] MAX_GROUPS_RESET = GCOUNT_W'(64);
	localparam logic [GCOUNT_W-1:0] GCOUNT_CEIL = GCOUNT_W'(127);

	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LOG2 = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRANULE_LOG2 = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GROUPS = 2'd2;

	localparam logic [1:0] MODE_CLAIM = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_ADD = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_GROUP_LIMIT = 3'd1;
	localparam logic [2:0] ST_OUTSIDE = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_RESIDENT = 2'd1;
	localparam logic [1:0] EV_DISCARD = 2'd2;

endpackage

FILE: hw/rtl/grt_ram.sv
module grt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/granule_residency_tracker.sv
// Channel   Direction  Signals                                      Handshake
// config    in         cfg_we, cfg_index, cfg_data                  write at cfg_we
// request   in         start, mode, frame_index                     start && !busy
// result    out        done, status, granule_event,                 one-cycle strobe
//                      granule_offset, new_group
//
// A request is taken every cycle unless busy; results pass s1, then output regs.
// The counter memory is read in the cycle of acceptance and written back in
// the next, with forwarding when consecutive requests hit the same granule.
// After reset a clearing pass writes zero to all 65536 counters, one per
// cycle, with busy high; configuration writes are taken throughout.
// Results cannot be held off by the receiver.
module granule_residency_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [grt_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [grt_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           mode,
	input  logic [grt_pkg::FRAME_W-1:0]          frame_index,
	output logic                                 done,
	output logic [2:0]                           status,
	output logic [1:0]                           granule_event,
	output logic [grt_pkg::OFFSET_W-1:0]         granule_offset,
	output logic [grt_pkg::GROUP_W-1:0]          new_group
);

	logic [grt_pkg::LOG2_W-1:0]   frame_log2_q;
	logic [grt_pkg::LOG2_W-1:0]   granule_log2_q;
	logic [grt_pkg::GCOUNT_W-1:0] max_groups_q;
	logic [grt_pkg::GCOUNT_W-1:0] group_count_q;

	logic                         clearing_q;
	logic [grt_pkg::FRAME_W-1:0]  clr_addr_q;

	logic [grt_pkg::LOG2_W-1:0]   f_eff;
	logic [grt_pkg::LOG2_W-1:0]   g_diff;
	logic [grt_pkg::SHIFT_W-1:0]  d_eff;
	logic [grt_pkg::FRAME_W-1:0]  gidx;
	logic                         accept;

	logic                         valid_s1;
	logic [1:0]                   mode_s1;
	logic [grt_pkg::FRAME_W-1:0]  frame_s1;
	logic [grt_pkg::FRAME_W-1:0]  gidx_s1;
	logic [grt_pkg::LOG2_W-1:0]   f_s1;
	logic [grt_pkg::SHIFT_W-1:0]  d_s1;
	logic                         fwd_s1;
	logic [grt_pkg::COUNT_W-1:0]  fwd_data_s1;

	logic [grt_pkg::COUNT_W-1:0]  rdata;
	logic [grt_pkg::COUNT_W-1:0]  cnt;
	logic [grt_pkg::CMP_W-1:0]    lim;
	logic [grt_pkg::GCOUNT_W-1:0] glimit;
	logic                         outside;
	logic                         wr_s1;
	logic [grt_pkg::COUNT_W-1:0]  new_cnt;
	logic                         add_ok;
	logic [2:0]                   status_d;
	logic [1:0]                   event_d;
	logic [grt_pkg::OFFSET_W-1:0] offset_d;
	logic [grt_pkg::GROUP_W-1:0]  group_d;

	logic                         ram_we;
	logic [grt_pkg::FRAME_W-1:0]  ram_waddr;
	logic [grt_pkg::COUNT_W-1:0]  ram_wdata;

	logic                         done_q;
	logic [2:0]                   status_q;
	logic [1:0]                   event_q;
	logic [grt_pkg::OFFSET_W-1:0] offset_q;
	logic [grt_pkg::GROUP_W-1:0]  group_q;

	assign busy = clearing_q;
	assign accept = start && !clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_log2_q <= grt_pkg::FRAME_LOG2_RESET;
			granule_log2_q <= grt_pkg::GRANULE_LOG2_RESET;
			max_groups_q <= grt_pkg::MAX_GROUPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				grt_pkg::CFG_FRAME_LOG2: frame_log2_q <= cfg_data[grt_pkg::LOG2_W-1:0];
				grt_pkg::CFG_GRANULE_LOG2: granule_log2_q <= cfg_data[grt_pkg::LOG2_W-1:0];
				grt_pkg::CFG_MAX_GROUPS: max_groups_q <= cfg_data[grt_pkg::GCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		priority if (frame_log2_q < grt_pkg::FRAME_LOG2_MIN) begin
			f_eff = grt_pkg::FRAME_LOG2_MIN;
		end else if (frame_log2_q > grt_pkg::FRAME_LOG2_MAX) begin
			f_eff = grt_pkg::FRAME_LOG2_MAX;
		end else begin
			f_eff = frame_log2_q;
		end
		g_diff = (granule_log2_q > f_eff) ? granule_log2_q - f_eff : '0;
		if (g_diff > grt_pkg::LOG2_W'(grt_pkg::GROUP_LOG2)) begin
			d_eff = grt_pkg::SHIFT_W'(grt_pkg::GROUP_LOG2);
		end else begin
			d_eff = g_diff[grt_pkg::SHIFT_W-1:0];
		end
		gidx = frame_index >> d_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			frame_s1 <= frame_index;
			gidx_s1 <= gidx;
			f_s1 <= f_eff;
			d_s1 <= d_eff;
			fwd_s1 <= wr_s1 && (gidx_s1 == gidx);
			fwd_data_s1 <= new_cnt;
		end
	end

	always_comb begin
		cnt = fwd_s1 ? fwd_data_s1 : rdata;
		lim = grt_pkg::CMP_W'(1) << d_s1;
		if (lim > grt_pkg::CMP_W'(grt_pkg::COUNT_MAX)) begin
			lim = grt_pkg::CMP_W'(grt_pkg::COUNT_MAX);
		end
		glimit = (max_groups_q > grt_pkg::GCOUNT_W'(grt_pkg::MAX_GROUPS)) ?
			grt_pkg::GCOUNT_W'(grt_pkg::MAX_GROUPS) : max_groups_q;
		outside = grt_pkg::GCOUNT_W'(frame_s1[grt_pkg::FRAME_W-1:grt_pkg::GROUP_LOG2])
			>= group_count_q;
		status_d = grt_pkg::ST_OK;
		event_d = grt_pkg::EV_NONE;
		group_d = '0;
		add_ok = 1'b0;
		wr_s1 = 1'b0;
		new_cnt = cnt;
		unique case (mode_s1)
			grt_pkg::MODE_ADD: begin
				if (group_count_q >= glimit || group_count_q == grt_pkg::GCOUNT_CEIL) begin
					status_d = grt_pkg::ST_GROUP_LIMIT;
				end else begin
					add_ok = 1'b1;
					group_d = group_count_q[grt_pkg::GROUP_W-1:0];
				end
			end
			grt_pkg::MODE_CLAIM: begin
				priority if (outside) begin
					status_d = grt_pkg::ST_OUTSIDE;
				end else if (grt_pkg::CMP_W'(cnt) >= lim) begin
					status_d = grt_pkg::ST_OVERFLOW;
				end else begin
					wr_s1 = 1'b1;
					new_cnt = cnt + 1'b1;
					if (cnt == '0) begin
						event_d = grt_pkg::EV_RESIDENT;
					end
				end
			end
			grt_pkg::MODE_RELEASE: begin
				priority if (outside) begin
					status_d = grt_pkg::ST_OUTSIDE;
				end else if (cnt == '0) begin
					status_d = grt_pkg::ST_EMPTY;
				end else begin
					wr_s1 = 1'b1;
					new_cnt = cnt - 1'b1;
					if (cnt == grt_pkg::COUNT_W'(1)) begin
						event_d = grt_pkg::EV_DISCARD;
					end
				end
			end
			default: ;
		endcase
		wr_s1 = wr_s1 && valid_s1;
		add_ok = add_ok && valid_s1;
		offset_d = '0;
		if (event_d != grt_pkg::EV_NONE) begin
			offset_d = grt_pkg::OFFSET_W'(gidx_s1)
				<< ((grt_pkg::LOG2_W + 1)'(f_s1) + (grt_pkg::LOG2_W + 1)'(d_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q <= '0;
		end else if (add_ok) begin
			group_count_q <= group_count_q + 1'b1;
		end
	end

	always_comb begin
		if (clearing_q) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we = wr_s1;
			ram_waddr = gidx_s1;
			ram_wdata = new_cnt;
		end
	end

	grt_ram #(
		.WIDTH(grt_pkg::COUNT_W),
		.DEPTH(grt_pkg::DEPTH)
	) u_counts (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(gidx),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_d;
			event_q <= event_d;
			offset_q <= offset_d;
			group_q <= group_d;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign granule_event = event_q;
	assign granule_offset = offset_q;
	assign new_group = group_q;

endmodule

FILE: tb/granule_residency_tracker_tb.sv
module granule_residency_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [grt_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 205;
	localparam int HOT_N = 8;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] ev;
		logic [grt_pkg::OFFSET_W-1:0] offset;
		logic [grt_pkg::GROUP_W-1:0] grp;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [grt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [grt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = grt_pkg::MODE_CLAIM;
	logic [grt_pkg::FRAME_W-1:0] frame_index = '0;
	logic done;
	logic [2:0] status;
	logic [1:0] granule_event;
	logic [grt_pkg::OFFSET_W-1:0] granule_offset;
	logic [grt_pkg::GROUP_W-1:0] new_group;

	logic [grt_pkg::COUNT_W-1:0] resident_ctr [grt_pkg::DEPTH];
	logic [grt_pkg::GCOUNT_W-1:0] groups_added;
	logic [grt_pkg::LOG2_W-1:0] frame_log2_r;
	logic [grt_pkg::LOG2_W-1:0] granule_log2_r;
	logic [grt_pkg::GCOUNT_W-1:0] max_groups_r;
	outcome_t outcome_q [$];

	int cycles = 0;
	int n_results = 0;
	int n_resident = 0;
	int n_discard = 0;
	int n_refused = 0;
	int n_settings = 0;
	int n_mismatch = 0;

	always #6 clk = ~clk;

	granule_residency_tracker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.mode(mode),
		.frame_index(frame_index),
		.done(done),
		.status(status),
		.granule_event(granule_event),
		.granule_offset(granule_offset),
		.new_group(new_group)
	);

	function automatic int eff_frame_log2();
		if (frame_log2_r < grt_pkg::FRAME_LOG2_MIN) return int'(grt_pkg::FRAME_LOG2_MIN);
		if (frame_log2_r > grt_pkg::FRAME_LOG2_MAX) return int'(grt_pkg::FRAME_LOG2_MAX);
		return int'(frame_log2_r);
	endfunction

	function automatic int granule_shift();
		int f;
		int d;
		f = eff_frame_log2();
		d = (int'(granule_log2_r) > f) ? int'(granule_log2_r) - f : 0;
		if (d > grt_pkg::GROUP_LOG2) d = grt_pkg::GROUP_LOG2;
		return d;
	endfunction

	function automatic outcome_t track_request(input logic [1:0] m,
			input logic [grt_pkg::FRAME_W-1:0] fr);
		outcome_t r;
		int f;
		int d;
		int gidx;
		int cap;
		int lim;
		logic [grt_pkg::COUNT_W-1:0] cnt;
		logic [63:0] off;
		r = '0;
		if (m == grt_pkg::MODE_ADD) begin
			lim = (max_groups_r > grt_pkg::MAX_GROUPS) ? grt_pkg::MAX_GROUPS :
				int'(max_groups_r);
			if (int'(groups_added) >= lim || groups_added >= grt_pkg::GCOUNT_CEIL) begin
				r.status = grt_pkg::ST_GROUP_LIMIT;
			end else begin
				r.grp = groups_added[grt_pkg::GROUP_W-1:0];
				groups_added = groups_added + 1'b1;
			end
		end else if (m != MODE_UNUSED) begin
			f = eff_frame_log2();
			d = granule_shift();
			gidx = int'(fr) >> d;
			cap = 1 << d;
			if (cap > grt_pkg::COUNT_MAX) cap = grt_pkg::COUNT_MAX;
			cnt = resident_ctr[gidx];
			if ((int'(fr) >> grt_pkg::GROUP_LOG2) >= int'(groups_added)) begin
				r.status = grt_pkg::ST_OUTSIDE;
			end else if (m == grt_pkg::MODE_CLAIM) begin
				if (int'(cnt) >= cap) begin
					r.status = grt_pkg::ST_OVERFLOW;
				end else begin
					resident_ctr[gidx] = cnt + 1'b1;
					if (cnt == 0) r.ev = grt_pkg::EV_RESIDENT;
				end
			end else begin
				if (cnt == 0) begin
					r.status = grt_pkg::ST_EMPTY;
				end else begin
					resident_ctr[gidx] = cnt - 1'b1;
					if (cnt == 1) r.ev = grt_pkg::EV_DISCARD;
				end
			end
			if (r.ev != grt_pkg::EV_NONE) begin
				off = 64'(gidx) << (f + d);
				r.offset = off[grt_pkg::OFFSET_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int fresh_frame();
		if (groups_added == 0) return $urandom_range(0, 65535);
		return $urandom_range(0, int'(groups_added) * (1 << grt_pkg::GROUP_LOG2) - 1);
	endfunction

	task automatic send_req(input logic [1:0] m, input logic [grt_pkg::FRAME_W-1:0] fr,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// start stays high when the next beat follows at once.
		start <= 1'b1;
		mode <= m;
		frame_index <= fr;
		@(posedge clk);
		while (busy) @(posedge clk);
		outcome_q.insert(outcome_q.size(), track_request(m, fr));
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [grt_pkg::CFG_INDEX_W-1:0] idx,
			input logic [grt_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			grt_pkg::CFG_FRAME_LOG2: frame_log2_r = val[grt_pkg::LOG2_W-1:0];
			grt_pkg::CFG_GRANULE_LOG2: granule_log2_r = val[grt_pkg::LOG2_W-1:0];
			grt_pkg::CFG_MAX_GROUPS: max_groups_r = val[grt_pkg::GCOUNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [grt_pkg::CFG_DATA_W-1:0] fl,
			input logic [grt_pkg::CFG_DATA_W-1:0] gl,
			input logic [grt_pkg::CFG_DATA_W-1:0] mg);
		wait_idle();
		write_reg(grt_pkg::CFG_FRAME_LOG2, fl);
		write_reg(grt_pkg::CFG_GRANULE_LOG2, gl);
		write_reg(grt_pkg::CFG_MAX_GROUPS, mg);
		n_settings++;
	endtask

	task automatic test_first_group();
		send_req(grt_pkg::MODE_CLAIM, 16'h0000, 0);
		send_req(grt_pkg::MODE_RELEASE, 16'hFFFF, pick_gap());
		send_req(MODE_UNUSED, 16'hFFFF, 0);
		send_req(grt_pkg::MODE_ADD, 16'hFFFF, 0);
		send_req(grt_pkg::MODE_CLAIM, 16'h0000, 0);
		send_req(grt_pkg::MODE_CLAIM, 16'h0000, 0);
		send_req(grt_pkg::MODE_RELEASE, 16'h0000, pick_gap());
		send_req(grt_pkg::MODE_RELEASE, 16'h0000, 0);
		send_req(grt_pkg::MODE_CLAIM, 16'h03FF, pick_gap());
		send_req(grt_pkg::MODE_CLAIM, 16'h0400, 0);
		send_req(grt_pkg::MODE_RELEASE, 16'h03FF, 0);
	endtask

	task automatic test_group_limits();
		apply_setting(grt_pkg::CFG_DATA_W'(grt_pkg::FRAME_LOG2_RESET),
			grt_pkg::CFG_DATA_W'(grt_pkg::GRANULE_LOG2_RESET), 7'd1);
		send_req(grt_pkg::MODE_ADD, 16'h0000, 0);
		apply_setting(grt_pkg::CFG_DATA_W'(grt_pkg::FRAME_LOG2_RESET),
			grt_pkg::CFG_DATA_W'(grt_pkg::GRANULE_LOG2_RESET), 7'd0);
		send_req(grt_pkg::MODE_ADD, 16'h5A5A, 0);
		apply_setting(7'd0, 7'd31, 7'd127);
		send_req(grt_pkg::MODE_ADD, 16'h0000, 0);
		send_req(grt_pkg::MODE_ADD, 16'hFFFF, pick_gap());
		send_req(grt_pkg::MODE_ADD, 16'h0000, 0);
	endtask

	task automatic test_size_clamps();
		send_req(grt_pkg::MODE_CLAIM, 16'h0FFF, 0);
		send_req(grt_pkg::MODE_CLAIM, 16'h0C00, 0);
		send_req(grt_pkg::MODE_RELEASE, 16'h0FFF, pick_gap());
		send_req(grt_pkg::MODE_RELEASE, 16'h0C00, 0);
		apply_setting(7'd31, 7'd0, 7'd127);
		send_req(grt_pkg::MODE_CLAIM, 16'h0FFF, 0);
		send_req(grt_pkg::MODE_RELEASE, 16'h0FFF, 0);
		wait_idle();
		write_reg(CFG_UNUSED, 7'h7F);
		send_req(MODE_UNUSED, 16'h0000, 0);
	endtask

	task automatic run_traffic(input int n_items, input bit bursty);
		int hot [HOT_N];
		int k;
		int pick;
		int d;
		int fr;
		int h;
		logic [1:0] m;
		d = granule_shift();
		for (k = 0; k < HOT_N; k++) hot[k] = fresh_frame();
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				m = grt_pkg::MODE_ADD;
				fr = $urandom_range(0, 65535);
			end else if (pick < 8) begin
				m = MODE_UNUSED;
				fr = $urandom_range(0, 65535);
			end else if (pick < 18) begin
				m = $urandom_range(0, 1) ? grt_pkg::MODE_RELEASE : grt_pkg::MODE_CLAIM;
				fr = $urandom_range(0, 65535);
			end else begin
				h = $urandom_range(0, HOT_N - 1);
				if (pick < 22) hot[h] = fresh_frame();
				m = $urandom_range(0, 1) ? grt_pkg::MODE_RELEASE : grt_pkg::MODE_CLAIM;
				fr = ((hot[h] >> d) << d) | ($urandom & ((1 << d) - 1));
			end
			send_req(m, fr[grt_pkg::FRAME_W-1:0], bursty ? 0 : pick_gap());
		end
	endtask

	task automatic test_random_traffic();
		apply_setting(7'd12, 7'd12, 7'd127);
		run_traffic(PHASE_ITEMS, 1'b0);
		apply_setting(7'd9, 7'd11, 7'd64);
		run_traffic(PHASE_ITEMS, 1'b1);
		apply_setting(7'd18, 7'd20, 7'd100);
		run_traffic(PHASE_ITEMS, 1'b0);
		apply_setting(7'd31, 7'd9, 7'd5);
		run_traffic(PHASE_ITEMS, 1'b0);
		apply_setting(7'd0, 7'd12, 7'd127);
		run_traffic(PHASE_ITEMS, 1'b1);
		apply_setting(7'd10, 7'd13, 7'd64);
		run_traffic(PHASE_ITEMS, 1'b0);
		apply_setting(7'd16, 7'd28, 7'd127);
		run_traffic(PHASE_ITEMS, 1'b0);
		apply_setting(grt_pkg::CFG_DATA_W'($urandom_range(0, 127)),
			grt_pkg::CFG_DATA_W'($urandom_range(0, 127)),
			grt_pkg::CFG_DATA_W'($urandom_range(0, 127)));
		run_traffic(PHASE_ITEMS, 1'b0);
	endtask

	always @(posedge clk) begin : result_check
		outcome_t got;
		outcome_t want;
		if (arst_n && done) begin
			got = {status, granule_event, granule_offset, new_group};
			n_results++;
			if (outcome_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: unexpected result status=%0d event=%0d offset=%0h group=%0d",
						$realtime, got.status, got.ev, got.offset, got.grp);
			end else begin
				want = outcome_q.pop_front();
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10) begin
						$display("%0t: expected status=%0d event=%0d offset=%0h group=%0d",
							$realtime, want.status, want.ev, want.offset, want.grp);
						$display("%0t:   actual status=%0d event=%0d offset=%0h group=%0d",
							$realtime, got.status, got.ev, got.offset, got.grp);
					end
				end
				if (want.ev == grt_pkg::EV_RESIDENT) n_resident++;
				if (want.ev == grt_pkg::EV_DISCARD) n_discard++;
				if (want.status != grt_pkg::ST_OK) n_refused++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycles, outcome_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < grt_pkg::DEPTH; i++) resident_ctr[i] = '0;
		groups_added = '0;
		frame_log2_r = grt_pkg::FRAME_LOG2_RESET;
		granule_log2_r = grt_pkg::GRANULE_LOG2_RESET;
		max_groups_r = grt_pkg::MAX_GROUPS_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_first_group();
		test_group_limits();
		test_size_clamps();
		test_random_traffic();
		wait_idle();
		repeat (10) @(posedge clk);
		n_mismatch += outcome_q.size();
		$display("Checked %0d results over %0d register settings with %0d groups added.",
			n_results, n_settings, groups_added);
		$display("Granules made resident %0d times, discarded %0d times; %0d requests refused.",
			n_resident, n_discard, n_refused);
		if (n_mismatch == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches found.", n_mismatch);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: granule_residency_tracker.f
hw/rtl/grt_pkg.sv
hw/rtl/grt_ram.sv
hw/rtl/granule_residency_tracker.sv
tb/granule_residency_tracker_tb.sv
